### src/mdgs_pkg.sv
// Shared constants, types and the exponential table builder for the Metropolis sampler.
package mdgs_pkg;

    // Field and register widths
    localparam int POS_W   = 24;
    localparam int REG_W   = 23;
    localparam int CNT_W   = 21;
    localparam int STEP_W  = 22;
    localparam int RAND_W  = 32;
    localparam int EXP_W   = 31;
    localparam int CFG_IDX_W = 3;

    // Default parameter values
    localparam int DEF_FRAC_BITS       = 16;
    localparam int DEF_EXP_TABLE_DEPTH = 256;

    // Register reset values
    localparam logic signed [POS_W-1:0] RST_START  = '0;
    localparam logic [REG_W-1:0]        RST_MU     = 23'd52429;
    localparam logic [REG_W-1:0]        RST_K      = 23'd91022;
    localparam logic [REG_W-1:0]        RST_DELTA  = 23'd131072;
    localparam logic [CNT_W-1:0]        RST_EQUIL  = 21'd1000;
    localparam logic [CNT_W-1:0]        RST_SAMP   = 21'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START   = 3'd0,
        CFG_MU      = 3'd1,
        CFG_K       = 3'd2,
        CFG_DELTA   = 3'd3,
        CFG_EQUIL   = 3'd4,
        CFG_SAMPLES = 3'd5
    } t_cfg_idx;

    // Command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_OFS  = 10'b0000000010,
        S_XN   = 10'b0000000100,
        S_SQ   = 10'b0000001000,
        S_SCL  = 10'b0000010000,
        S_LUT  = 10'b0000100000,
        S_WSQ  = 10'b0001000000,
        S_HI1  = 10'b0010000000,
        S_HI2  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    // Entry idx of exp(-16*i/depth) in Q1.30
    function automatic logic [EXP_W-1:0] exp_entry(input int depth, input int idx);
        logic [63:0]        h;
        logic [63:0]        term;
        logic [63:0]        r;
        logic [63:0]        e;
        logic signed [63:0] sum;
        h    = (64'd1 << 34) / 64'(depth);
        term = 64'd1 << 30;
        sum  = 64'sd1 <<< 30;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * h) >> 30) / 64'(n);
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        r = (sum < 0) ? 64'd0 : $unsigned(sum);
        e = 64'd1 << 30;
        for (int i = 1; i <= idx; i++) begin
            e = (e * r + (64'd1 << 29)) >> 30;
        end
        return e[EXP_W-1:0];
    endfunction

endpackage

### src/mdgs_mul.sv
// Shared unsigned multiplier with a registered product.
module mdgs_mul
    import mdgs_pkg::*;
#(
    parameter int MUL_W = 40
) (
    input  logic                 i_clk,
    input  logic [MUL_W-1:0]     i_a,
    input  logic [MUL_W-1:0]     i_b,
    output logic [2*MUL_W-1:0]   o_prod
);

    logic [2*MUL_W-1:0] r_prod;

    // Register the product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### src/mdgs_exp_lut.sv
// Table lookup of exp(-a) from the scaled squared distance.
module mdgs_exp_lut
    import mdgs_pkg::*;
#(
    parameter int FRAC_BITS       = DEF_FRAC_BITS,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH,
    parameter int PROD_W          = 80
) (
    input  logic [PROD_W-1:0] i_prod,
    output logic [EXP_W-1:0]  o_exp
);

    localparam int LOG2D = $clog2(EXP_TABLE_DEPTH);
    localparam int LIM_B = 2 * FRAC_BITS + 4;
    localparam int A_W   = FRAC_BITS + 4;
    localparam int SC_W  = A_W + LOG2D;

    logic [EXP_W-1:0] w_tab [EXP_TABLE_DEPTH];
    logic [LOG2D-1:0] w_idx;
    logic [SC_W-1:0]  w_scaled;
    logic             w_over;

    // Build the constant table
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
        assign w_tab[g] = exp_entry(EXP_TABLE_DEPTH, g);
    end

    // Arguments of sixteen or more give zero; scale the argument to the table depth
    assign w_over   = |i_prod[PROD_W-1:LIM_B];
    assign w_scaled = SC_W'(i_prod[LIM_B-1:FRAC_BITS]) * SC_W'(EXP_TABLE_DEPTH);
    assign w_idx    = w_scaled[A_W +: LOG2D];
    assign o_exp    = w_over ? '0 : w_tab[w_idx];

endmodule

### src/metropolis_double_gaussian_sampler_unit.sv
// Top level: Metropolis sampler sequencer, state and stream ports.
//
//  channel   direction  handshake               contents
//  s_axis    in         tvalid/tready           tdata: rand_move, rand_accept; tuser: cmd
//  m_axis    out        tvalid/tready           tdata: sample_x, accepted, accept_count; tlast
//  cfg       in         i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// A step word keeps the sequencer busy from S_OFS through S_FIN, so no new word is taken
// until it ends; the single shared multiplier does thirteen products in turn.
// A restart word or a step after the run is taken in S_IDLE and leaves the sequencer there.
// Synchronous active-low reset clears position, counters and registers to defaults.
// The final cycle of a sample step waits while the previous result word is not taken.
module metropolis_double_gaussian_sampler_unit
    import mdgs_pkg::*;
#(
    parameter int FRAC_BITS       = DEF_FRAC_BITS,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,   // [31:0] rand_move, [63:32] rand_accept
    input  logic                 s_axis_tuser,   // [0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // [23:0] sample_x, [24] accepted,
                                                 // [45:25] accept_count, [47:46] zero
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data
);

    localparam int MUL_W  = (48 - FRAC_BITS > 33) ? (48 - FRAC_BITS) : 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DW     = POS_W + 2;

    // Configuration registers
    logic signed [POS_W-1:0] r_start;
    logic [REG_W-1:0]        r_mu, r_k, r_delta;
    logic [CNT_W-1:0]        r_equil, r_samp;

    // Sequencer and walker state
    t_state                  r_state;
    logic [1:0]              r_j;
    logic [RAND_W-1:0]       r_u, r_ua;
    logic signed [POS_W-1:0] r_pos, r_xn;
    logic [STEP_W-1:0]       r_step;
    logic [CNT_W-1:0]        r_acc_tot;
    logic [31:0]             r_s;
    logic [63:0]             r_wold, r_wnew, r_hi;

    // Result word
    logic                    r_oval;
    logic signed [POS_W-1:0] r_ox;
    logic                    r_oacc;
    logic [CNT_W-1:0]        r_ocnt;
    logic                    r_olast;

    logic [MUL_W-1:0]        w_a, w_b;
    logic [PROD_W-1:0]       w_p;
    logic [EXP_W-1:0]        w_e;
    logic signed [DW-1:0]    w_base, w_d, w_off, w_xn;
    logic [DW-1:0]           w_ad;
    logic signed [POS_W-1:0] w_xsat;
    logic [STEP_W-1:0]       w_total;
    logic [63:0]             w_hi;
    logic                    w_acc, w_fout, w_fgo, w_in_acc;
    logic [CNT_W-1:0]        w_cnt_nx;

    mdgs_mul #(.MUL_W(MUL_W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_p)
    );

    mdgs_exp_lut #(
        .FRAC_BITS       (FRAC_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
        .PROD_W          (PROD_W)
    ) u_lut (
        .i_prod (w_p),
        .o_exp  (w_e)
    );

    // Distance to one of the peaks for the current table pass
    assign w_base = r_j[1] ? DW'(r_xn) : DW'(r_pos);
    assign w_d    = r_j[0] ? (w_base + $signed({3'b000, r_mu}))
                           : (w_base - $signed({3'b000, r_mu}));
    assign w_ad   = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);

    // Proposal offset and saturated new position
    assign w_off  = $signed({2'b00, w_p[54:31]}) - $signed({3'b000, r_delta});
    assign w_xn   = DW'(r_pos) + w_off;
    always_comb begin
        if (w_xn < -(DW'(1) <<< (POS_W - 1))) begin
            w_xsat = {1'b1, {(POS_W-1){1'b0}}};
        end else if (w_xn > ((DW'(1) <<< (POS_W - 1)) - DW'(1))) begin
            w_xsat = {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            w_xsat = w_xn[POS_W-1:0];
        end
    end

    // Select multiplier operands; hold the low product while the final cycle waits
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_OFS: begin
                w_a = MUL_W'(r_delta);
                w_b = MUL_W'(r_u);
            end
            S_SQ: begin
                w_a = MUL_W'(w_ad);
                w_b = MUL_W'(w_ad);
            end
            S_SCL: begin
                w_a = w_p[FRAC_BITS +: MUL_W];
                w_b = MUL_W'(r_k);
            end
            S_WSQ: begin
                w_a = MUL_W'(r_s);
                w_b = MUL_W'(r_s);
            end
            S_HI1: begin
                w_a = MUL_W'(r_ua);
                w_b = MUL_W'(r_wold[63:32]);
            end
            S_HI2, S_FIN: begin
                w_a = MUL_W'(r_ua);
                w_b = MUL_W'(r_wold[31:0]);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Acceptance test and step bookkeeping
    assign w_total  = {1'b0, r_equil} + {1'b0, r_samp};
    assign w_hi     = r_hi + {32'd0, w_p[63:32]};
    assign w_acc    = w_hi < r_wnew;
    assign w_fout   = r_step >= {1'b0, r_equil};
    assign w_fgo    = !(w_fout && r_oval && !m_axis_tready);
    assign w_cnt_nx = r_acc_tot + CNT_W'(w_acc);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= RST_START;
            r_mu    <= RST_MU;
            r_k     <= RST_K;
            r_delta <= RST_DELTA;
            r_equil <= RST_EQUIL;
            r_samp  <= RST_SAMP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START:   r_start <= i_cfg_data;
                CFG_MU:      r_mu    <= i_cfg_data[REG_W-1:0];
                CFG_K:       r_k     <= i_cfg_data[REG_W-1:0];
                CFG_DELTA:   r_delta <= i_cfg_data[REG_W-1:0];
                CFG_EQUIL:   r_equil <= i_cfg_data[CNT_W-1:0];
                CFG_SAMPLES: r_samp  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequence one step through the shared multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_j       <= '0;
            r_pos     <= RST_START;
            r_step    <= '0;
            r_acc_tot <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser == CMD_RESTART) begin
                            r_pos     <= r_start;
                            r_step    <= '0;
                            r_acc_tot <= '0;
                        end else if (r_step < w_total) begin
                            r_state <= S_OFS;
                        end
                    end
                end
                S_OFS: r_state <= S_XN;
                S_XN: begin
                    r_j     <= '0;
                    r_state <= S_SQ;
                end
                S_SQ:  r_state <= S_SCL;
                S_SCL: r_state <= S_LUT;
                S_LUT: begin
                    if (r_j[0]) begin
                        r_state <= S_WSQ;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_WSQ: begin
                    if (r_j[1]) begin
                        r_state <= S_HI1;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_HI1: r_state <= S_HI2;
                S_HI2: r_state <= S_FIN;
                S_FIN: begin
                    if (w_fgo) begin
                        if (w_acc) begin
                            r_pos <= r_xn;
                        end
                        if (w_fout) begin
                            r_acc_tot <= w_cnt_nx;
                        end
                        r_step  <= r_step + STEP_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold step operands and partial results
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_u  <= s_axis_tdata[31:0];
            r_ua <= s_axis_tdata[63:32];
        end
        if (r_state == S_XN) begin
            r_xn <= w_xsat;
        end
        if (r_state == S_LUT) begin
            r_s <= r_j[0] ? (r_s + {1'b0, w_e}) : {1'b0, w_e};
        end
        if (r_state == S_SQ && r_j == 2'd2) begin
            r_wold <= w_p[63:0];
        end
        if (r_state == S_HI1) begin
            r_wnew <= w_p[63:0];
        end
        if (r_state == S_HI2) begin
            r_hi <= w_p[63:0];
        end
    end

    // Drive the result word; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (r_state == S_FIN && w_fgo && w_fout) begin
            r_oval <= 1'b1;
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_fgo && w_fout) begin
            r_ox    <= w_acc ? r_xn : r_pos;
            r_oacc  <= w_acc;
            r_ocnt  <= w_cnt_nx;
            r_olast <= (r_step + STEP_W'(1)) == w_total;
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {2'b00, r_ocnt, r_oacc, r_ox};
    assign m_axis_tlast  = r_olast;

    // A finished sample step always leaves a result word
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_fgo && w_fout) |=> m_axis_tvalid)
        else $error("sample step finished without a result word");

    // Accepted count never passes the step count
    a_cnt_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_acc_tot} <= r_step)
        else $error("accept count above step count");

    // The last marker comes only with the final sample of the run
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_fgo && w_fout) |=> (m_axis_tlast == (r_step == w_total)))
        else $error("last marker does not match the end of the run");

    // Position moves only at a restart or at the end of a step
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN && !(w_in_acc && s_axis_tuser == CMD_RESTART))
        |=> $stable(r_pos))
        else $error("position changed outside a step end or restart");

endmodule
